// ----- rtl/scix_pkg.sv -----
`default_nettype none

package scix_pkg;

   // Operation selector carried on the request tuser
   localparam logic OP_DECODE = 1'b0;
   localparam logic OP_ENCODE = 1'b1;

   localparam int MAX_BYTES = 5;

   localparam int BYTE_W  = 8;
   localparam int VALUE_W = 32;
   localparam int MAG_W   = 31;                 // magnitude bits of a value
   localparam int REM_W   = MAG_W - 6;          // magnitude left after the first byte
   localparam int POS_W   = 3;                  // bytes seen of the value in progress
   localparam int EXT_W   = 34;                 // seven bits shifted by up to 27

   localparam int REQ_TDATA_W = 40;             // in_byte, in_value
   localparam int RSP_TDATA_W = 40;             // out_byte, out_value
   localparam int RSP_TUSER_W = 3;

   // Response tuser bit positions
   localparam int USER_BYTE_VALID   = 0;
   localparam int USER_VALUE_VALID  = 1;
   localparam int USER_DECODE_ERROR = 2;

   // One classified request as it waits between the front and back
   typedef struct packed {
      logic              op;
      logic [BYTE_W-1:0] in_byte;
      logic              neg;
      logic [MAG_W-1:0]  mag;
   } item_type;

endpackage

`default_nettype wire

// ----- rtl/scix_front.sv -----
`default_nettype none

module scix_front
   import scix_pkg::*;
(
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // [7:0] in_byte, [39:8] in_value
   input  wire logic [0:0]             req_tuser,   // [0] op
   input  wire logic                   queue_full,
   output logic                        push,
   output item_type                    push_item
);

   logic [VALUE_W-1:0] value;
   logic [VALUE_W-1:0] negated;

   assign value   = req_tdata[REQ_TDATA_W-1:BYTE_W];
   assign negated = VALUE_W'(0) - value;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   // Split sign and magnitude; the most negative value saturates
   always_comb begin
      push_item.op      = req_tuser[0];
      push_item.in_byte = req_tdata[BYTE_W-1:0];
      push_item.neg     = value[VALUE_W-1];
      if (!value[VALUE_W-1]) begin
         push_item.mag = value[MAG_W-1:0];
      end else if (negated[VALUE_W-1]) begin
         push_item.mag = {MAG_W{1'b1}};
      end else begin
         push_item.mag = negated[MAG_W-1:0];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/scix_queue.sv -----
`default_nettype none

module scix_queue
   import scix_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output logic          full,
   input  wire logic     pop,
   output logic          head_valid,
   output item_type      head_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type             slots_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/scix_back.sv -----
`default_nettype none

module scix_back
   import scix_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   head_valid,
   input  wire item_type               head_item,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,   // [7:0] out_byte, [39:8] out_value
   output logic [RSP_TUSER_W-1:0]      rsp_tuser,   // [0] byte_valid, [1] value_valid,
                                                    // [2] decode_error
   output logic                        rsp_tlast
);

   typedef enum logic {
      ST_IDLE,
      ST_ENCODE
   } state_type;

   state_type                state_ff, state_in;
   logic [MAG_W-1:0]         acc_ff, acc_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic                     neg_ff, neg_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [RSP_TUSER_W-1:0]   rsp_user_ff, rsp_user_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     out_free;
   logic [BYTE_W-1:0]        b;
   logic [EXT_W-1:0]         ext;
   logic [MAG_W-1:0]         mag_new;
   logic                     overflow;
   logic [VALUE_W-1:0]       value_pos;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign b        = head_item.in_byte;

   // Place the seven new magnitude bits of a continuation byte
   always_comb begin
      unique case (pos_ff)
         3'd1:    ext = EXT_W'(b[6:0]) << 6;
         3'd2:    ext = EXT_W'(b[6:0]) << 13;
         3'd3:    ext = EXT_W'(b[6:0]) << 20;
         default: ext = EXT_W'(b[6:0]) << 27;
      endcase
   end

   assign overflow = |ext[EXT_W-1:MAG_W];
   assign mag_new  = acc_ff | ext[MAG_W-1:0];

   always_comb begin
      logic             emit_value;
      logic             value_neg;
      logic [MAG_W-1:0] value_mag;

      emit_value = 1'b0;
      value_neg  = neg_ff;
      value_mag  = acc_ff;

      state_in     = state_ff;
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      pop          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid && out_free) begin
               pop = 1'b1;
               if (head_item.op == OP_ENCODE) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = RSP_TDATA_W'({head_item.neg,
                                               |head_item.mag[MAG_W-1:6],
                                               head_item.mag[5:0]});
                  rsp_user_in  = '0;
                  rsp_user_in[USER_BYTE_VALID] = 1'b1;
                  rsp_last_in  = (head_item.mag[MAG_W-1:6] == '0);
                  rem_in       = head_item.mag[MAG_W-1:6];
                  if (head_item.mag[MAG_W-1:6] != '0) begin
                     state_in = ST_ENCODE;
                  end
               end else if (pos_ff == '0) begin
                  if (b[6]) begin
                     neg_in = b[7];
                     acc_in = MAG_W'(b[5:0]);
                     pos_in = POS_W'(1);
                  end else begin
                     emit_value = 1'b1;
                     value_neg  = b[7];
                     value_mag  = MAG_W'(b[5:0]);
                  end
               end else if (pos_ff >= POS_W'(MAX_BYTES) || overflow) begin
                  // Too many bytes or magnitude past 31 bits: flag and restart
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_user_in  = '0;
                  rsp_user_in[USER_DECODE_ERROR] = 1'b1;
                  rsp_last_in  = 1'b1;
                  acc_in       = '0;
                  pos_in       = '0;
                  neg_in       = 1'b0;
               end else if (b[7]) begin
                  acc_in = mag_new;
                  pos_in = pos_ff + POS_W'(1);
               end else begin
                  emit_value = 1'b1;
                  value_mag  = mag_new;
               end
            end
         end
         ST_ENCODE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_TDATA_W'({|rem_ff[REM_W-1:7], rem_ff[6:0]});
               rsp_user_in  = '0;
               rsp_user_in[USER_BYTE_VALID] = 1'b1;
               rsp_last_in  = (rem_ff[REM_W-1:7] == '0);
               rem_in       = rem_ff >> 7;
               if (rem_ff[REM_W-1:7] == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      value_pos = {1'b0, value_mag};
      if (emit_value) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {(value_neg ? VALUE_W'(0) - value_pos : value_pos),
                         {BYTE_W{1'b0}}};
         rsp_user_in  = '0;
         rsp_user_in[USER_VALUE_VALID] = 1'b1;
         rsp_last_in  = 1'b1;
         acc_in       = '0;
         pos_in       = '0;
         neg_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         pos_ff       <= '0;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         pos_ff       <= pos_in;
         neg_ff       <= neg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ----- rtl/signed_compact_index_codec.sv -----
// Path: an accepted request is written into the queue, popped by the back engine, and its
// first response loaded into the output register that drives rsp_tvalid. Throughput:
// one decode byte per cycle when idle, one byte of an encode value (one to five) per
// cycle, while the single output register of the back engine is not held by a stall.
// Reset: synchronous, active high; empties the queue, drops any pending response and
// clears the decode in progress.
`default_nettype none

module signed_compact_index_codec
   import scix_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // [7:0] in_byte, [39:8] in_value
   input  wire logic [0:0]             req_tuser,   // [0] op
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,   // [7:0] out_byte, [39:8] out_value
   output logic [RSP_TUSER_W-1:0]      rsp_tuser,   // [0] byte_valid, [1] value_valid,
                                                    // [2] decode_error
   output logic                        rsp_tlast
);

   // Front: take a request transfer whenever the queue has room, split sign
   // and magnitude for encode requests
   logic     queue_full;
   logic     push;
   item_type push_item;

   scix_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   // Queue: decouple the front from the back so either side may stall
   logic     pop;
   logic     head_valid;
   item_type head_item;

   scix_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // Back: hold the decode accumulator, emit encoded bytes one per cycle while the
   // response register is free, and drive the response register
   scix_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Every response is exactly one kind: a byte, a value or an error
   a_one_kind : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot(rsp_tuser))
      else $error("response carries no kind or more than one");

   // Values and errors always close their request
   a_value_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[USER_BYTE_VALID]) |-> rsp_tlast)
      else $error("value or error response without tlast");

   // A byte that is not the last one carries a continuation flag
   a_byte_cont : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[USER_BYTE_VALID] && !rsp_tlast)
         |-> (rsp_tdata[6] || rsp_tdata[7]))
      else $error("non-final encoded byte lacks continuation flag");

   // The queue only drains what it holds
   a_pop_valid : assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");

endmodule

`default_nettype wire

// ----- bench/signed_compact_index_codec_tb.sv -----
module signed_compact_index_codec_tb;
   import scix_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] MAG_LIMIT = 32'h7FFF_FFFF;   // largest magnitude a value may carry
   localparam int          RSP_LATENCY = 20;            // settle cycles after the last response
   localparam int          RANDOM_ITEMS = 300;

   // One response as the codec should present it
   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic [31:0] out_value;
      logic        value_valid;
      logic        decode_error;
      logic        last;
   } codec_result_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // [7:0] in_byte, [39:8] in_value
   logic [0:0]             req_tuser;   // [0] op
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // [7:0] out_byte, [39:8] out_value
   logic [RSP_TUSER_W-1:0] rsp_tuser;   // [0] byte_valid, [1] value_valid, [2] decode_error
   logic                   rsp_tlast;

   // Responses owed by the codec, oldest first
   codec_result_type pending_rsp[$];

   // Decode progress as the codec should hold it
   logic [30:0] dec_mag;
   logic [2:0]  dec_pos;
   logic        dec_neg;

   int error_count;
   int items_sent;
   bit send_idle_en;
   bit recv_idle_en;

   signed_compact_index_codec DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the codec hangs on either channel
   initial begin
      #5_000_000;
      $display("signed_compact_index_codec verification failed");
      $finish;
   end

   // Build the byte sequence of one value, first byte in the lowest bits.
   // The most negative input saturates to -(2^31-1).
   function automatic int encode_compact(input logic [31:0] value,
                                         output logic [MAX_BYTES*8-1:0] seq);
      logic [31:0] mag;
      logic [7:0]  b;
      int          n;
      seq = '0;
      if (value[31]) begin
         mag = -value;
         if (mag > MAG_LIMIT) begin
            mag = MAG_LIMIT;
         end
         b = 8'h80;
      end else begin
         mag = value;
         b   = 8'h00;
      end
      b   = b | {2'b00, mag[5:0]};
      mag = mag >> 6;
      if (mag != 0) begin
         b[6] = 1'b1;
      end
      seq[7:0] = b;
      n = 1;
      while (mag != 0 && n < MAX_BYTES) begin
         b   = {1'b0, mag[6:0]};
         mag = mag >> 7;
         if (mag != 0) begin
            b[7] = 1'b1;
         end
         seq[n*8 +: 8] = b;
         n++;
      end
      return n;
   endfunction

   // Spread magnitudes over every length class, both signs, with the odd
   // most negative value thrown in.
   function automatic logic [31:0] random_value();
      logic [31:0] mag;
      if ($urandom_range(0, 49) == 0) begin
         return 32'h8000_0000;
      end
      mag = $urandom >> $urandom_range(0, 31);
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   // Work out the responses one accepted request owes and queue them
   task automatic predict_codec(input logic op, input logic [7:0] in_byte,
                                input logic [31:0] in_value);
      codec_result_type       r;
      logic [MAX_BYTES*8-1:0] seq;
      logic [63:0]            grown;
      int                     n;
      bit                     emit_value;
      bit                     emit_error;
      if (op == OP_ENCODE) begin
         n = encode_compact(in_value, seq);
         for (int i = 0; i < n; i++) begin
            r            = '0;
            r.out_byte   = seq[i*8 +: 8];
            r.byte_valid = 1'b1;
            r.last       = (i == n - 1);
            pending_rsp.push_back(r);
         end
      end else begin
         emit_value = 1'b0;
         emit_error = 1'b0;
         if (dec_pos == 0) begin
            // First byte: sign, continuation, six magnitude bits
            dec_neg = in_byte[7];
            dec_mag = {25'b0, in_byte[5:0]};
            if (in_byte[6]) begin
               dec_pos = 3'd1;
            end else begin
               emit_value = 1'b1;
            end
         end else if (dec_pos >= MAX_BYTES) begin
            emit_error = 1'b1;
         end else begin
            grown = {33'b0, dec_mag} | ({57'b0, in_byte[6:0]} << (6 + 7 * (dec_pos - 1)));
            if (grown > {32'b0, MAG_LIMIT}) begin
               emit_error = 1'b1;
            end else begin
               dec_mag = grown[30:0];
               if (in_byte[7]) begin
                  dec_pos = dec_pos + 3'd1;
               end else begin
                  emit_value = 1'b1;
               end
            end
         end
         if (emit_value || emit_error) begin
            r              = '0;
            r.decode_error = emit_error;
            r.value_valid  = emit_value;
            if (emit_value) begin
               r.out_value = dec_neg ? -{1'b0, dec_mag} : {1'b0, dec_mag};
            end
            r.last = 1'b1;
            pending_rsp.push_back(r);
            dec_mag = '0;
            dec_pos = '0;
            dec_neg = 1'b0;
         end
      end
   endtask

   // Offer one request and hold it until the codec takes the transfer.
   // Valid stays high afterward so a back-to-back request keeps it up.
   task automatic send_item(input logic op, input logic [7:0] in_byte,
                            input logic [31:0] in_value);
      int gap;
      gap = send_idle_en ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {in_value, in_byte};
      req_tuser  <= op;
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_codec(op, in_byte, in_value);
      items_sent++;
   endtask

   // Feed a byte run to the decoder, optionally slipping encodes in between
   task automatic send_byte_run(input logic [MAX_BYTES*8+7:0] bytes, input int n,
                                input bit interleave);
      for (int i = 0; i < n; i++) begin
         if (interleave && $urandom_range(0, 9) == 0) begin
            send_item(OP_ENCODE, 8'($urandom), random_value());
         end
         send_item(OP_DECODE, bytes[i*8 +: 8], $urandom);
      end
   endtask

   // Hold the sender off until every owed response has come back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= 40) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
         end
      end
   endtask

   // Response side: stall at random, then compare each transfer with the
   // oldest owed response.
   initial begin : result_checker
      int               stall;
      codec_result_type want;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = recv_idle_en ? $urandom_range(0, 16) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         if (pending_rsp.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response: expected none, actual tdata %h tuser %b tlast %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = pending_rsp.pop_front();
            check_field("out_byte", {24'b0, want.out_byte}, {24'b0, rsp_tdata[7:0]});
            check_field("byte_valid", 32'(want.byte_valid),
                        32'(rsp_tuser[USER_BYTE_VALID]));
            check_field("out_value", want.out_value, rsp_tdata[39:8]);
            check_field("value_valid", 32'(want.value_valid),
                        32'(rsp_tuser[USER_VALUE_VALID]));
            check_field("decode_error", 32'(want.decode_error),
                        32'(rsp_tuser[USER_DECODE_ERROR]));
            check_field("last", 32'(want.last), 32'(rsp_tlast));
         end
      end
   end

   // Single-byte values: zero, negative zero, largest negative one-byter
   task automatic test_decode_single_byte();
      send_byte_run({8'hBF, 8'h80, 8'h00}, 3, 1'b0);
      wait_for_results();
   endtask

   // Two-byte value, then the largest positive five-byte value
   task automatic test_decode_multi_byte();
      send_byte_run({8'h01, 8'h41}, 2, 1'b0);
      send_byte_run({8'h0F, 8'hFF, 8'hFF, 8'hFF, 8'h7F}, 5, 1'b0);
      wait_for_results();
   endtask

   // Magnitude overflow on the fifth byte (negative), then a sixth byte
   task automatic test_decode_errors();
      send_byte_run({8'h1F, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 5, 1'b0);
      send_byte_run({8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'h40}, 6, 1'b0);
      wait_for_results();
   endtask

   // Encode extremes, including the saturating most negative input
   task automatic test_encode_extremes();
      send_item(OP_ENCODE, 8'h00, 32'h0000_0000);
      send_item(OP_ENCODE, 8'hFF, 32'hFFFF_FFFF);
      send_item(OP_ENCODE, 8'h00, 32'h7FFF_FFFF);
      send_item(OP_ENCODE, 8'hFF, 32'h8000_0000);
      wait_for_results();
   endtask

   // An encode in the middle of a decode must leave the decode intact
   task automatic test_interleave();
      send_item(OP_DECODE, 8'h41, $urandom);
      send_item(OP_ENCODE, 8'($urandom), 32'd64);
      send_item(OP_DECODE, 8'h01, $urandom);
      wait_for_results();
   endtask

   // Mostly well-formed byte runs with random content, plus encodes,
   // truncated runs, overflowing runs, overlong runs and raw noise
   task automatic test_random_traffic();
      logic [MAX_BYTES*8-1:0] seq;
      logic [MAX_BYTES*8+7:0] run;
      int                     n;
      int                     pick;
      int                     start;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         // Switch idling on and off now and then to get busy stretches
         if ($urandom_range(0, 39) == 0) begin
            send_idle_en = $urandom_range(0, 1);
            recv_idle_en = $urandom_range(0, 1);
         end
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            n = encode_compact(random_value(), seq);
            send_byte_run({8'h00, seq}, n, 1'b1);
         end else if (pick < 75) begin
            send_item(OP_ENCODE, 8'($urandom), random_value());
         end else if (pick < 82) begin
            // Drop the tail of a run; the next run merges into it
            n = encode_compact(random_value(), seq);
            if (n > 1) begin
               send_byte_run({8'h00, seq}, $urandom_range(1, n - 1), 1'b0);
            end
         end else if (pick < 88) begin
            // Fifth byte carries magnitude bits past bit 30
            run = {$urandom_range(0, 1) ? 8'h80 : 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
            run[7:0] = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 1'b1, 6'($urandom)};
            for (int i = 1; i < 4; i++) begin
               run[i*8 +: 8] = {1'b1, 7'($urandom)};
            end
            run[32 +: 8] = {1'($urandom), 7'($urandom_range(16, 127))};
            send_byte_run(run, 5, 1'b0);
         end else if (pick < 94) begin
            // Five continued bytes and a sixth one
            run      = {8'($urandom), 40'b0};
            run[7:0] = 8'($urandom) | 8'h40;
            for (int i = 1; i < 5; i++) begin
               run[i*8 +: 8] = {1'b1, 7'($urandom)};
            end
            send_byte_run(run, 6, 1'b0);
         end else begin
            send_item(OP_DECODE, 8'($urandom), $urandom);
         end
      end
      wait_for_results();
   endtask

   initial begin
      error_count  = 0;
      items_sent   = 0;
      send_idle_en = 1'b1;
      recv_idle_en = 1'b1;
      dec_mag      = '0;
      dec_pos      = '0;
      dec_neg      = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_decode_single_byte();
      test_decode_multi_byte();
      test_decode_errors();
      test_encode_extremes();
      test_interleave();
      test_random_traffic();

      // Let any stray response show up before the verdict
      repeat (RSP_LATENCY) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("signed_compact_index_codec verification clean");
      end else begin
         $display("signed_compact_index_codec verification failed");
      end
      $finish;
   end

endmodule
